// ===== hdl/histogram_level_state_finder_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the level state finder
// Shared property forms, clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_LEVEL_STATE_FINDER_CORE_DEFINES_SVH
`define HISTOGRAM_LEVEL_STATE_FINDER_CORE_DEFINES_SVH

// same-cycle implication
`define HLSF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hlsf assertion failed");

// next-cycle implication
`define HLSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hlsf assertion failed");

`endif

// ===== hdl/hlsf_pkg.sv =====
// ----------------------------------------------------------------------------
// hlsf_pkg
// Constants, types and helpers shared by the level state finder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hlsf_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int NUM_BINS    = 32;

    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 13;
    localparam int ADDR_W   = $clog2(MAX_SAMPLES);
    localparam int TOT_W    = $clog2(MAX_SAMPLES + 1);
    localparam int BOUND_W  = $clog2(NUM_BINS * 65535 + 1);
    localparam int LVL_W    = 22;
    localparam int RAW_W    = $clog2((2 * NUM_BINS + 1) * 65535 + 1);
    localparam int STATES_W = 6;
    localparam int LOG_W    = 3;
    localparam int CNT_W    = $clog2(NUM_BINS + 3);
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_THRESHOLD = 2'd1;

    localparam logic [SAMPLE_W-1:0] BIN_WIDTH_RST = 16'd10;
    localparam logic [COUNT_W-1:0]  THRESHOLD_RST = 13'd500;

    typedef struct packed {
        logic                valid;
        logic                claimed;
        logic [SAMPLE_W-1:0] offset;
    } t_token;

    typedef struct packed {
        logic clear;
        logic shift;
    } t_chain_ctrl;

    function automatic logic [LVL_W-1:0] sat_lvl(input logic [RAW_W-1:0] v);
        logic [LVL_W-1:0] r;
        if (v > RAW_W'({LVL_W{1'b1}})) begin
            r = {LVL_W{1'b1}};
        end else begin
            r = v[LVL_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [LOG_W-1:0] floor_log2(input logic [STATES_W-1:0] v);
        logic [LOG_W-1:0] r;
        r = '0;
        for (int k = 1; k < STATES_W; k++) begin
            if (v[k]) begin
                r = LOG_W'(k);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/hlsf_cell.sv =====
// ----------------------------------------------------------------------------
// hlsf_cell
// One histogram bin: upper bound, count, and a token stage of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module hlsf_cell (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  hlsf_pkg::t_chain_ctrl       i_ctrl,
    input  wire [hlsf_pkg::SAMPLE_W-1:0] i_w,
    input  wire [hlsf_pkg::BOUND_W-1:0] i_prev_bound,
    output logic [hlsf_pkg::BOUND_W-1:0] o_bound,
    input  hlsf_pkg::t_token            i_tok,
    output hlsf_pkg::t_token            o_tok,
    input  wire [hlsf_pkg::COUNT_W-1:0] i_next_count,
    output logic [hlsf_pkg::COUNT_W-1:0] o_count
);
    import hlsf_pkg::*;

    logic [BOUND_W-1:0] r_bound;
    logic [COUNT_W-1:0] r_count;
    t_token             r_tok;
    t_token             n_tok;
    logic               hit;

    // offset falls in (prev_bound, bound] when no earlier cell took it
    assign hit = i_tok.valid && !i_tok.claimed
                 && (BOUND_W'(i_tok.offset) <= r_bound);

    always_comb begin
        n_tok         = i_tok;
        n_tok.claimed = i_tok.claimed | hit;
    end

    always_ff @(posedge i_clk) begin
        r_bound <= i_prev_bound + BOUND_W'(i_w);
        if (!i_rst_n) begin
            r_tok   <= '0;
            r_count <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_ctrl.clear) begin
                r_count <= '0;
            end else if (i_ctrl.shift) begin
                r_count <= i_next_count;
            end else if (hit) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    assign o_bound = r_bound;
    assign o_tok   = r_tok;
    assign o_count = r_count;

endmodule

`default_nettype wire

// ===== hdl/hlsf_chain.sv =====
// ----------------------------------------------------------------------------
// hlsf_chain
// Row of bin cells; tokens walk up the row, counts shift down to cell 0.
// ----------------------------------------------------------------------------
`default_nettype none

module hlsf_chain (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  hlsf_pkg::t_chain_ctrl        i_ctrl,
    input  wire [hlsf_pkg::SAMPLE_W-1:0] i_w,
    input  hlsf_pkg::t_token             i_tok,
    output hlsf_pkg::t_token             o_tail_tok,
    output logic [hlsf_pkg::COUNT_W-1:0] o_head_count
);
    import hlsf_pkg::*;

    logic [BOUND_W-1:0] bound [NUM_BINS+1];
    t_token             tok   [NUM_BINS+1];
    logic [COUNT_W-1:0] cnt   [NUM_BINS+1];

    assign bound[0]      = '0;
    assign tok[0]        = i_tok;
    assign cnt[NUM_BINS] = '0;

    for (genvar g = 0; g < NUM_BINS; g++) begin : g_cell
        hlsf_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (i_ctrl),
            .i_w          (i_w),
            .i_prev_bound (bound[g]),
            .o_bound      (bound[g+1]),
            .i_tok        (tok[g]),
            .o_tok        (tok[g+1]),
            .i_next_count (cnt[g+1]),
            .o_count      (cnt[g])
        );
    end

    assign o_tail_tok   = tok[NUM_BINS];
    assign o_head_count = cnt[0];

endmodule

`default_nettype wire

// ===== hdl/histogram_level_state_finder_core.sv =====
// ----------------------------------------------------------------------------
// histogram_level_state_finder_core
// Loads samples, bins offsets from the minimum, reports bins above threshold.
// ----------------------------------------------------------------------------
// Loading: one sample per cycle, no result for a non-final sample.
// After the final sample: a clear phase, then each stored sample read through the
// sample memory read port and passed up the bin chain, a drain of the bin chain,
// then one bin per cycle while the output register is free, plus summary.
// Synchronous active-low reset clears control, bins and registers to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module histogram_level_state_finder_core (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire [hlsf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [15:0]                    i_cfg_data,
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  wire [15:0]                    i_sample_value,
    input  wire                           i_is_final,
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output logic                          o_is_summary,
    output logic [21:0]                   o_level_half_units,
    output logic                          o_big_step,
    output logic [5:0]                    o_state_count,
    output logic [2:0]                    o_device_log2,
    output logic [21:0]                   o_step_sum_half_units,
    output logic                          o_bins_overflow,
    output logic                          o_last_of_run
);
    import hlsf_pkg::*;

    `include "histogram_level_state_finder_core_defines.svh"

    typedef enum logic [2:0] {
        S_LOAD, S_CLEAR, S_HIST, S_DRAIN, S_SCAN, S_SUM
    } t_state;

    t_state              r_state;
    logic [SAMPLE_W-1:0] r_bin_width;
    logic [COUNT_W-1:0]  r_thr;
    logic [TOT_W-1:0]    r_total;
    logic [SAMPLE_W-1:0] r_min;
    logic [TOT_W-1:0]    r_addr;
    logic [SAMPLE_W-1:0] r_rd_data;
    logic                r_rd_vld;
    logic [CNT_W-1:0]    r_cnt;
    logic [RAW_W-1:0]    r_lvl;
    logic [LVL_W-1:0]    r_prev;
    logic [LVL_W-1:0]    r_sum;
    logic [STATES_W-1:0] r_found;
    logic                r_ovf;
    logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];

    logic [SAMPLE_W-1:0] w_eff;
    logic                in_acc;
    logic                do_write;
    logic                rd_en;
    logic                out_free;
    t_chain_ctrl         ctrl;
    t_token              in_tok;
    t_token              tail_tok;
    logic [COUNT_W-1:0]  head_count;
    logic [LVL_W-1:0]    lvl;
    logic [LVL_W-1:0]    diff;
    logic                big;
    logic [LVL_W:0]      sum_raw;
    logic [LVL_W-1:0]    sum_sat;
    logic                emit;

    assign w_eff       = (r_bin_width == '0) ? SAMPLE_W'(1) : r_bin_width;
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_LOAD);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign do_write    = in_acc && (r_total < TOT_W'(MAX_SAMPLES));
    assign rd_en       = (r_state == S_HIST) && (r_addr < r_total);
    assign out_free    = !o_out_valid || !i_out_stall;

    assign ctrl = '{clear: (r_state == S_CLEAR), shift: (r_state == S_SCAN) && out_free};

    always_comb begin
        in_tok.valid   = r_rd_vld;
        in_tok.offset  = (r_rd_data >= r_min) ? r_rd_data - r_min : '0;
        in_tok.claimed = (in_tok.offset == '0);
    end

    hlsf_chain u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_w          (w_eff),
        .i_tok        (in_tok),
        .o_tail_tok   (tail_tok),
        .o_head_count (head_count)
    );

    // level of the bin now at the head of the chain
    assign lvl     = sat_lvl(r_lvl);
    assign diff    = lvl - r_prev;
    assign big     = ({1'b0, diff} > ((LVL_W+1)'(w_eff) << 1) + (LVL_W+1)'(2));
    assign sum_raw = {1'b0, r_sum} + {1'b0, diff};
    assign sum_sat = sat_lvl(RAW_W'(sum_raw));
    assign emit    = ctrl.shift && (head_count > r_thr);

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            mem[r_total[ADDR_W-1:0]] <= i_sample_value;
        end
        r_rd_data <= mem[r_addr[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_bin_width <= BIN_WIDTH_RST;
            r_thr       <= THRESHOLD_RST;
            r_total     <= '0;
            r_min       <= '1;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_cnt       <= '0;
            r_lvl       <= '0;
            r_prev      <= '0;
            r_sum       <= '0;
            r_found     <= '0;
            r_ovf       <= 1'b0;
            o_out_valid <= 1'b0;
            o_is_summary          <= 1'b0;
            o_level_half_units    <= '0;
            o_big_step            <= 1'b0;
            o_state_count         <= '0;
            o_device_log2         <= '0;
            o_step_sum_half_units <= '0;
            o_bins_overflow       <= 1'b0;
            o_last_of_run         <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_BIN_WIDTH:       r_bin_width <= i_cfg_data;
                    REG_COUNT_THRESHOLD: r_thr       <= i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            r_rd_vld <= rd_en;
            if (tail_tok.valid && !tail_tok.claimed) begin
                r_ovf <= 1'b1;
            end

            case (r_state)
                S_LOAD: begin
                    if (do_write) begin
                        r_total <= r_total + 1'b1;
                        if (i_sample_value < r_min) begin
                            r_min <= i_sample_value;
                        end
                    end
                    if (in_acc && i_is_final) begin
                        r_state <= S_CLEAR;
                        r_cnt   <= '0;
                    end
                end
                S_CLEAR: begin
                    // bounds settle up the chain while counts are cleared
                    r_ovf <= 1'b0;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(NUM_BINS)) begin
                        r_state <= S_HIST;
                        r_addr  <= '0;
                    end
                end
                S_HIST: begin
                    if (rd_en) begin
                        r_addr <= r_addr + 1'b1;
                    end else begin
                        r_state <= S_DRAIN;
                        r_cnt   <= '0;
                    end
                end
                S_DRAIN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(NUM_BINS + 2)) begin
                        r_state <= S_SCAN;
                        r_cnt   <= '0;
                        r_lvl   <= RAW_W'(w_eff);
                        r_prev  <= '0;
                        r_sum   <= '0;
                        r_found <= '0;
                    end
                end
                S_SCAN: begin
                    if (ctrl.shift) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_lvl <= r_lvl + (RAW_W'(w_eff) << 1);
                        if (r_cnt == CNT_W'(NUM_BINS - 1)) begin
                            r_state <= S_SUM;
                        end
                    end
                    if (emit) begin
                        r_prev  <= lvl;
                        r_found <= r_found + 1'b1;
                        if (big) begin
                            r_sum <= sum_sat;
                        end
                        o_out_valid           <= 1'b1;
                        o_is_summary          <= 1'b0;
                        o_level_half_units    <= lvl;
                        o_big_step            <= big;
                        o_state_count         <= '0;
                        o_device_log2         <= '0;
                        o_step_sum_half_units <= '0;
                        o_bins_overflow       <= r_ovf;
                        o_last_of_run         <= 1'b0;
                    end
                end
                S_SUM: begin
                    if (out_free) begin
                        o_out_valid           <= 1'b1;
                        o_is_summary          <= 1'b1;
                        o_level_half_units    <= '0;
                        o_big_step            <= 1'b0;
                        o_state_count         <= r_found;
                        o_device_log2         <= floor_log2(r_found);
                        o_step_sum_half_units <= r_sum;
                        o_bins_overflow       <= r_ovf;
                        o_last_of_run         <= 1'b1;
                        r_total               <= '0;
                        r_min                 <= '1;
                        r_state               <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    `HLSF_ASSERT_NOW(a_total_bound, 1'b1, r_total <= TOT_W'(MAX_SAMPLES))
    `HLSF_ASSERT_NOW(a_chain_idle_in_scan, r_state == S_SCAN, !tail_tok.valid)
    `HLSF_ASSERT_NOW(a_level_nonzero, o_out_valid && !o_is_summary, o_level_half_units != '0)
    `HLSF_ASSERT_NEXT(a_sum_to_load, (r_state == S_SUM) && out_free, r_state == S_LOAD)

endmodule

`default_nettype wire
